// ===== hw/rtl/pidc_pkg.sv =====
// Shared types, register indexes and a saturating add helper for the clamped PID controller.
package pidc_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_OUT_MIN   = 3'd3;
    localparam logic [2:0] REG_OUT_MAX   = 3'd4;
    localparam logic [2:0] REG_STEP_TIME = 3'd5;
    localparam logic [2:0] REG_STEP_RATE = 3'd6;

    // Width of the multiplier digit taken from the narrow operand each cycle.
    localparam int DIGIT_W = 16;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_POST  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    // Product sequence for one in-window sample.
    typedef enum logic [2:0] {
        OP_INT  = 3'd0,  // error * dt, added into the integral
        OP_DER  = 3'd1,  // (error - last error) * rate
        OP_PRO  = 3'd2,  // gain_p * error
        OP_ITG  = 3'd3,  // gain_i * integral
        OP_DGN  = 3'd4,  // gain_d * derivative
        OP_DAL  = 3'd5   // previous product * 0.8
    } op_t;

    // Signed 64-bit add that saturates instead of wrapping.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? S64_MIN : S64_MAX;
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

endpackage

// ===== hw/rtl/pid_controller_clamped.sv =====
// Clamped fixed-point PID controller with an APB register file and stream channels.
// An in-window sample goes through the item check, then a load, multiply and post step for
// each of six products, then a finish step and the done state. NDIG is the number of
// 16-bit digits of the narrow operand. Held and clear items go from check to done.
// Throughput: one item at a time; the next transfer can be taken the cycle after the result
// is registered. One shared 64x16 multiplier computes every product. Reset is synchronous.
module pid_controller_clamped #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int APB_DW    = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W   = 3 + $clog2(APB_DW / 8),
    localparam int IN_TDW    = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDW   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    // Input channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_TDW-1:0]    s_tdata,   // target, then measured, zero padded
    input  logic                 s_tuser,   // kind: 0 sample, 1 clear
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_TDW-1:0]   m_tdata,   // drive, zero padded
    output logic                 m_tuser    // held
);
    import pidc_pkg::*;

    localparam int W        = DATA_WIDTH;
    localparam int ADDR_LSB = $clog2(APB_DW / 8);
    // The narrow multiplier operand holds a gain, a step register or the 0.8 constant.
    localparam int BMAX     = (W > FRAC_BITS) ? W : FRAC_BITS;
    localparam int NDIG     = (BMAX + DIGIT_W - 1) / DIGIT_W;
    localparam int BPAD     = NDIG * DIGIT_W;
    localparam int PW       = 64 + BPAD;
    localparam int PPW      = 64 + DIGIT_W;
    localparam int DCW      = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam logic signed [W-1:0] D_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] D_MIN = {1'b1, {(W-1){1'b0}}};
    // round(0.8 * 2^FRAC_BITS)
    localparam logic [63:0] ALPHA = 64'((((64'd1 << FRAC_BITS) * 8) + 5) / 10);

    // Configuration registers.
    logic signed [W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [W-1:0] out_min_reg, out_max_reg;
    logic [W-2:0]        step_time_reg, step_rate_reg;

    // Item and controller state.
    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic                kind_reg;
    logic signed [W-1:0] target_reg, measured_reg;
    logic signed [W-1:0] err_reg, last_error_reg, last_drive_reg;
    logic signed [63:0]  error_sum_reg, deriv_reg, sum_reg;
    logic                held_reg;

    // Shared multiplier.
    logic [63:0]         a_mag_reg;
    logic [BPAD-1:0]     b_mag_reg;
    logic                neg_reg;
    logic [PW-1:0]       acc_reg;
    logic [DCW-1:0]      dig_cnt_reg;

    // Output register.
    logic                m_valid_reg;
    logic signed [W-1:0] out_drive_reg;
    logic                out_held_reg;

    // Configuration access.
    logic                cfg_write;
    logic [2:0]          cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[PADDR_W-1:ADDR_LSB];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_index)
            REG_GAIN_P:    prdata = APB_DW'($unsigned(gain_p_reg));
            REG_GAIN_I:    prdata = APB_DW'($unsigned(gain_i_reg));
            REG_GAIN_D:    prdata = APB_DW'($unsigned(gain_d_reg));
            REG_OUT_MIN:   prdata = APB_DW'($unsigned(out_min_reg));
            REG_OUT_MAX:   prdata = APB_DW'($unsigned(out_max_reg));
            REG_STEP_TIME: prdata = APB_DW'(step_time_reg);
            REG_STEP_RATE: prdata = APB_DW'(step_rate_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= W'(64'sd65536);
            gain_i_reg    <= W'(64'sd6554);
            gain_d_reg    <= W'(64'sd655);
            out_min_reg   <= W'(-64'sd655360);
            out_max_reg   <= W'(64'sd655360);
            step_time_reg <= (W-1)'(64'd6554);
            step_rate_reg <= (W-1)'(64'd655360);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= pwdata[W-1:0];
                REG_GAIN_I:    gain_i_reg    <= pwdata[W-1:0];
                REG_GAIN_D:    gain_d_reg    <= pwdata[W-1:0];
                REG_OUT_MIN:   out_min_reg   <= pwdata[W-1:0];
                REG_OUT_MAX:   out_max_reg   <= pwdata[W-1:0];
                REG_STEP_TIME: step_time_reg <= pwdata[W-2:0];
                REG_STEP_RATE: step_rate_reg <= pwdata[W-2:0];
                default: begin
                    // Addresses past the register list are ignored.
                end
            endcase
        end
    end

    // Stream handshakes. The block takes one item at a time, and only when idle.
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDW'($unsigned(out_drive_reg));
    assign m_tuser  = out_held_reg;

    logic in_xfer;
    logic out_free;
    assign in_xfer  = s_tvalid && s_tready;
    // The result slot can be loaded when empty or when its transfer completes now.
    assign out_free = !m_valid_reg || m_tready;

    // Error, saturated to the data width, and the measurement window test.
    logic signed [W:0]   err_wide;
    logic signed [W-1:0] err_sat;
    logic                in_window;

    assign err_wide  = {target_reg[W-1], target_reg} - {measured_reg[W-1], measured_reg};
    assign err_sat   = (err_wide[W] != err_wide[W-1]) ? (err_wide[W] ? D_MIN : D_MAX)
                                                      : err_wide[W-1:0];
    assign in_window = (measured_reg >= out_min_reg) && (measured_reg <= out_max_reg);

    // Operand selection for the current product.
    logic signed [63:0] op_a, op_b;
    logic [63:0]        op_a_mag, op_b_mag;

    always_comb begin
        case (op_reg)
            OP_INT: begin
                op_a = 64'(err_reg);
                op_b = signed'(64'(step_time_reg));
            end
            OP_DER: begin
                op_a = 64'(err_reg) - 64'(last_error_reg);
                op_b = signed'(64'(step_rate_reg));
            end
            OP_PRO: begin
                op_a = 64'(err_reg);
                op_b = 64'(gain_p_reg);
            end
            OP_ITG: begin
                op_a = error_sum_reg;
                op_b = 64'(gain_i_reg);
            end
            OP_DGN: begin
                op_a = deriv_reg;
                op_b = 64'(gain_d_reg);
            end
            OP_DAL: begin
                op_a = deriv_reg;
                op_b = signed'(ALPHA);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign op_a_mag = op_a[63] ? (64'd0 - $unsigned(op_a)) : $unsigned(op_a);
    assign op_b_mag = op_b[63] ? (64'd0 - $unsigned(op_b)) : $unsigned(op_b);

    // One 64x16 partial product a cycle, most significant digit first.
    logic [DIGIT_W-1:0] digit;
    logic [PPW-1:0]     part_prod;

    assign digit     = b_mag_reg[BPAD-1 -: DIGIT_W];
    assign part_prod = PPW'(a_mag_reg) * PPW'(digit);

    // Product shifted down by the fraction bits, truncated toward zero, saturated.
    logic               mul_over;
    logic signed [63:0] mul_mag;
    logic signed [63:0] mul_res;

    assign mul_over = |acc_reg[PW-1:FRAC_BITS+63];
    assign mul_mag  = {1'b0, acc_reg[FRAC_BITS+62:FRAC_BITS]};
    assign mul_res  = mul_over ? (neg_reg ? S64_MIN : S64_MAX)
                               : (neg_reg ? -mul_mag : mul_mag);

    // Final drive: saturate to the data width, then lower and upper clamp in that order.
    logic signed [W-1:0] drive_sat;
    logic signed [W-1:0] drive_clamped;

    always_comb begin
        if (sum_reg > 64'(D_MAX)) begin
            drive_sat = D_MAX;
        end else if (sum_reg < 64'(D_MIN)) begin
            drive_sat = D_MIN;
        end else begin
            drive_sat = sum_reg[W-1:0];
        end
        drive_clamped = drive_sat;
        if (drive_clamped < out_min_reg) begin
            drive_clamped = out_min_reg;
        end
        if (drive_clamped > out_max_reg) begin
            drive_clamped = out_max_reg;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (kind_reg || !in_window) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: state_next = S_MUL;
            S_MUL: begin
                if (dig_cnt_reg == '0) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                if (op_reg == OP_DAL) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_LOAD;
                end
            end
            S_FIN: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INT;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            last_drive_reg <= '0;
            held_reg       <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            // The result slot is loaded from the done state and empties on its transfer.
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        kind_reg     <= s_tuser;
                        target_reg   <= s_tdata[W-1:0];
                        measured_reg <= s_tdata[2*W-1:W];
                    end
                end
                S_CHECK: begin
                    held_reg <= 1'b1;
                    op_reg   <= OP_INT;
                    err_reg  <= err_sat;
                    if (kind_reg) begin
                        // A clear item resets the integral and the stored error only.
                        error_sum_reg  <= '0;
                        last_error_reg <= '0;
                    end
                end
                S_LOAD: begin
                    a_mag_reg   <= op_a_mag;
                    b_mag_reg   <= op_b_mag[BPAD-1:0];
                    neg_reg     <= op_a[63] ^ op_b[63];
                    acc_reg     <= '0;
                    dig_cnt_reg <= DCW'(NDIG - 1);
                end
                S_MUL: begin
                    acc_reg     <= (acc_reg << DIGIT_W) + PW'(part_prod);
                    b_mag_reg   <= b_mag_reg << DIGIT_W;
                    dig_cnt_reg <= dig_cnt_reg - 1'b1;
                end
                S_POST: begin
                    case (op_reg)
                        OP_INT: begin
                            error_sum_reg <= sat_add64(error_sum_reg, mul_res);
                            op_reg        <= OP_DER;
                        end
                        OP_DER: begin
                            deriv_reg <= mul_res;
                            op_reg    <= OP_PRO;
                        end
                        OP_PRO: begin
                            sum_reg <= mul_res;
                            op_reg  <= OP_ITG;
                        end
                        OP_ITG: begin
                            sum_reg <= sat_add64(sum_reg, mul_res);
                            op_reg  <= OP_DGN;
                        end
                        OP_DGN: begin
                            deriv_reg <= mul_res;
                            op_reg    <= OP_DAL;
                        end
                        OP_DAL: begin
                            sum_reg <= sat_add64(sum_reg, mul_res);
                            op_reg  <= OP_INT;
                        end
                        default: op_reg <= OP_INT;
                    endcase
                end
                S_FIN: begin
                    last_error_reg <= err_reg;
                    last_drive_reg <= drive_clamped;
                    held_reg       <= 1'b0;
                end
                S_DONE: begin
                    if (out_free) begin
                        out_drive_reg <= last_drive_reg;
                        out_held_reg  <= held_reg;
                    end
                end
            endcase
        end
    end

    // A new transfer always starts the item check in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == S_CHECK))
        else $error("input transfer did not start the item check");

    // The post step only follows the last multiplier digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POST) |-> ($past(state_reg) == S_MUL))
        else $error("product used before the multiplier finished");

    // With ordered limits a computed drive lies inside them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FIN) && (out_min_reg <= out_max_reg)) |=>
        ((last_drive_reg >= out_min_reg) && (last_drive_reg <= out_max_reg)))
        else $error("drive outside the clamp limits");

    // After a load from the done state, the result register carries the stored drive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) && out_free) |=>
        (m_valid_reg && (out_drive_reg == last_drive_reg)))
        else $error("result does not match the stored drive");

endmodule
